### sv/pett_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_pkg
// Shared types and constants of the periodic event timer table.
// ----------------------------------------------------------------------------
package pett_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TICK_STEP_DEF = 100;
  localparam int MAX_RESULTS   = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam int OP_W     = 2;
  localparam int PERIOD_W = 24;
  localparam int ID_W     = 16;
  localparam int KIND_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_CREATE = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATED = 2'd0,
    KIND_FIRED   = 2'd1,
    KIND_FULL    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_SHIFT_READ,
    ST_SHIFT_WRITE,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [PERIOD_W-1:0] period;
    logic [ID_W-1:0]     rid;
  } cmd_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] countdown;
    logic [ID_W-1:0]     ident;
  } entry_t;

endpackage
`default_nettype wire

### sv/pett_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_in_if
// Operation channel: tick, create or remove requests.
// ----------------------------------------------------------------------------
interface pett_in_if import pett_pkg::*; ();

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [PERIOD_W-1:0] period_ms;
  logic [ID_W-1:0]     remove_id;

  modport source (output valid, operation, period_ms, remove_id, input ready);
  modport sink   (input valid, operation, period_ms, remove_id, output ready);

endinterface
`default_nettype wire

### sv/pett_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_out_if
// Result channel: created, fired and table-full reports.
// ----------------------------------------------------------------------------
interface pett_out_if import pett_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ID_W-1:0]   event_id;
  logic              last;

  modport source (output valid, kind, event_id, last, input ready);
  modport sink   (input valid, kind, event_id, last, output ready);

endinterface
`default_nettype wire

### sv/pett_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_front
// Accepts operations, drops unused codes and forwards commands to the queue.
// ----------------------------------------------------------------------------
module pett_front import pett_pkg::*; (
  pett_in_if.sink evt_i,
  output logic    push_valid_o,
  input  logic    push_ready_i,
  output cmd_t    push_data_o
);

  logic legal;

  always_comb begin
    case (evt_i.operation)
      OP_TICK, OP_CREATE, OP_REMOVE: legal = 1'b1;
      default:                       legal = 1'b0;
    endcase
  end

  assign evt_i.ready         = push_ready_i;
  assign push_valid_o        = evt_i.valid && legal;
  assign push_data_o.op      = op_e'(evt_i.operation);
  assign push_data_o.period  = evt_i.period_ms;
  assign push_data_o.rid     = evt_i.remove_id;

endmodule
`default_nettype wire

### sv/pett_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_fifo
// Short command queue between the front and the execution unit.
// ----------------------------------------------------------------------------
module pett_fifo import pett_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(QUEUE_DEPTH);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          push, pop;

  assign push_ready_o = (fill_q != FULL);
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_d   = push ? wrap_inc(wr_q) : wr_q;
    rd_d   = pop ? wrap_inc(rd_q) : rd_q;
    fill_d = fill_q + FW'(push) - FW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### sv/pett_exec.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_exec
// Execution unit: walks the timer table in memory and emits results.
// ----------------------------------------------------------------------------
module pett_exec import pett_pkg::*; #(
  parameter  int SLOTS     = SLOTS_DEF,
  parameter  int TICK_STEP = TICK_STEP_DEF,
  localparam int IW        = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW        = $clog2(SLOTS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  cmd_t          cmd_i,
  output logic [CW-1:0] count_o,
  pett_out_if.source    res_o
);

  localparam logic [PERIOD_W-1:0] STEP = PERIOD_W'(TICK_STEP);
  localparam logic [CW-1:0]       FULL = CW'(SLOTS);
  localparam int                  RW   = $clog2(MAX_RESULTS + 1);
  localparam logic [RW-1:0]       RMAX = RW'(MAX_RESULTS);

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [IW-1:0]   idx_q, idx_d;
  op_e             op_q, op_d;
  logic [ID_W-1:0] rid_q, rid_d;
  logic [ID_W-1:0] nid_q, nid_d;
  logic            hold_v_q, hold_v_d;
  logic [ID_W-1:0] hold_id_q, hold_id_d;
  logic [RW-1:0]   nrep_q, nrep_d;
  logic            ov_q, ov_d;
  kind_e           okind_q, okind_d;
  logic [ID_W-1:0] oid_q, oid_d;
  logic            olast_q, olast_d;

  entry_t          mem [SLOTS];
  entry_t          rdata_q;
  entry_t          wdata;
  logic [IW-1:0]   raddr, waddr, nxt_idx;
  logic            we;

  logic            out_free, take, fires, report, ex_stall, match;
  logic            idx_is_top, shift_end;
  logic [CW-1:0]   last_idx;

  assign out_free   = !ov_q || res_o.ready;
  assign last_idx   = cnt_q - 1'b1;
  assign nxt_idx    = idx_q + 1'b1;
  assign idx_is_top = (CW'(idx_q) == last_idx);
  assign shift_end  = (CW'(nxt_idx) == last_idx);
  assign fires      = (rdata_q.countdown < STEP);
  assign report     = fires && (nrep_q < RMAX);
  assign ex_stall   = report && hold_v_q && !out_free;
  assign match      = (rdata_q.ident == rid_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_TICK, OP_REMOVE: if (cnt_q != '0) state_d = ST_READ;
            default:            state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (op_q == OP_TICK) begin
          if (!ex_stall) state_d = (idx_q == '0) ? ST_FLUSH : ST_READ;
        end else if (match) begin
          state_d = idx_is_top ? ST_IDLE : ST_SHIFT_READ;
        end else begin
          state_d = (idx_q == '0) ? ST_IDLE : ST_READ;
        end
      end
      ST_SHIFT_READ:  state_d = ST_SHIFT_WRITE;
      ST_SHIFT_WRITE: state_d = shift_end ? ST_IDLE : ST_SHIFT_READ;
      ST_FLUSH:       if (!hold_v_q || out_free) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    op_d      = op_q;
    rid_d     = rid_q;
    nid_d     = nid_q;
    hold_v_d  = hold_v_q;
    hold_id_d = hold_id_q;
    nrep_d    = nrep_q;
    ov_d      = ov_q && !res_o.ready;
    okind_d   = okind_q;
    oid_d     = oid_q;
    olast_d   = olast_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = rdata_q;
    raddr     = idx_q;
    take      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        take = (cmd_i.op == OP_CREATE) ? out_free : 1'b1;
        if (cmd_valid_i && take) begin
          op_d     = cmd_i.op;
          rid_d    = cmd_i.rid;
          idx_d    = IW'(last_idx);
          hold_v_d = 1'b0;
          nrep_d   = '0;
          if (cmd_i.op == OP_CREATE) begin
            ov_d    = 1'b1;
            olast_d = 1'b1;
            if (cnt_q == FULL) begin
              okind_d = KIND_FULL;
              oid_d   = '0;
            end else begin
              we              = 1'b1;
              waddr           = cnt_q[IW-1:0];
              wdata.period    = cmd_i.period;
              wdata.countdown = cmd_i.period;
              wdata.ident     = nid_q;
              okind_d         = KIND_CREATED;
              oid_d           = nid_q;
              nid_d           = nid_q + 1'b1;
              cnt_d           = cnt_q + 1'b1;
            end
          end
        end
      end
      ST_EXEC: begin
        if (op_q == OP_TICK) begin
          if (!ex_stall) begin
            we = 1'b1;
            wdata.countdown = fires ? rdata_q.period : rdata_q.countdown - STEP;
            if (report) begin
              if (hold_v_q) begin
                ov_d    = 1'b1;
                okind_d = KIND_FIRED;
                oid_d   = hold_id_q;
                olast_d = 1'b0;
              end
              hold_v_d  = 1'b1;
              hold_id_d = rdata_q.ident;
              nrep_d    = nrep_q + 1'b1;
            end
            if (idx_q != '0) idx_d = idx_q - 1'b1;
          end
        end else if (match) begin
          if (idx_is_top) cnt_d = cnt_q - 1'b1;
        end else if (idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end
      end
      ST_SHIFT_READ: raddr = nxt_idx;
      ST_SHIFT_WRITE: begin
        we = 1'b1;
        if (shift_end) cnt_d = cnt_q - 1'b1;
        else           idx_d = nxt_idx;
      end
      ST_FLUSH: begin
        if (hold_v_q && out_free) begin
          ov_d     = 1'b1;
          okind_d  = KIND_FIRED;
          oid_d    = hold_id_q;
          olast_d  = 1'b1;
          hold_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign cmd_ready_o    = take;
  assign count_o        = cnt_q;
  assign res_o.valid    = ov_q;
  assign res_o.kind     = okind_q;
  assign res_o.event_id = oid_q;
  assign res_o.last     = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      nid_q    <= '0;
      hold_v_q <= 1'b0;
      nrep_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      nid_q    <= nid_d;
      hold_v_q <= hold_v_d;
      nrep_q   <= nrep_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    op_q      <= op_d;
    rid_q     <= rid_d;
    hold_id_q <= hold_id_d;
    okind_q   <= okind_d;
    oid_q     <= oid_d;
    olast_q   <= olast_d;
  end

  // entry table
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/periodic_event_timer_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_event_timer_table_top
// Table of periodic event timers with create, remove and tick operations.
//
// channel  dir  handshake          payload
// evt_i    in   valid/ready        operation, period_ms, remove_id
// res_o    out  valid/ready        kind, event_id, last
//
// create is taken once the output register is free.
// tick on an empty table is taken without a walk; otherwise each live entry is
// read and then updated through the single read port of the entry memory, and
// a stalled output holds the walk while a report is pending.
// remove reads each entry searched, then moves later entries down one by one.
// reset empties the table through its fill count, no clearing pass.
// while the back stalls, the front accepts until the two-entry queue is full.
// ----------------------------------------------------------------------------
module periodic_event_timer_table_top import pett_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int TICK_STEP = TICK_STEP_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pett_in_if.sink    evt_i,
  pett_out_if.source res_o
);

  localparam int CW = $clog2(SLOTS + 1);

  logic          push_valid, push_ready, pop_valid, pop_ready;
  cmd_t          push_data, pop_data;
  logic [CW-1:0] count;

  pett_front u_front (
    .evt_i        (evt_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  pett_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  pett_exec #(
    .SLOTS     (SLOTS),
    .TICK_STEP (TICK_STEP)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_data),
    .count_o     (count),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(SLOTS))
    else $error("live count above table size");

  a_create_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && pop_data.op == OP_CREATE) |=> res_o.valid)
    else $error("create transfer without result");

  a_create_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && pop_data.op == OP_CREATE && count != CW'(SLOTS))
    |=> (count == $past(count) + CW'(1)))
    else $error("create did not add an entry");

  a_last_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != KIND_FIRED) |-> res_o.last)
    else $error("create report without last");
`endif

endmodule
`default_nettype wire

### verif/pett_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pett_checker
// Keeps its own copy of the timer table, updated on every operation transfer.
// Every result transfer is compared field by field with the oldest report
// still owed. A result with no report owed also counts as a mismatch.
// ----------------------------------------------------------------------------
module pett_checker import pett_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pett_in_if          evt_i,
  pett_out_if         res_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned reports_due_o
);

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] ident;
    logic            last;
  } report_t;

  logic [PERIOD_W-1:0] tmr_period    [SLOTS_DEF];
  logic [PERIOD_W-1:0] tmr_countdown [SLOTS_DEF];
  logic [ID_W-1:0]     tmr_ident     [SLOTS_DEF];
  int                  live_n       = 0;
  logic [ID_W-1:0]     next_id      = '0;
  report_t             due_reports[$];
  report_t             want;
  int unsigned         mismatch_cnt = 0;
  int unsigned         reports_due  = 0;

  assign mismatch_cnt_o = mismatch_cnt;
  assign reports_due_o  = reports_due;

  function automatic void apply_timer_op(input logic [OP_W-1:0]     op,
                                         input logic [PERIOD_W-1:0] period,
                                         input logic [ID_W-1:0]     rid);
    logic [ID_W-1:0] fired[$];
    int              hit;
    hit = -1;
    case (op)
      OP_CREATE: begin
        if (live_n >= SLOTS_DEF) begin
          due_reports.push_back('{KIND_FULL, {ID_W{1'b0}}, 1'b1});
        end else begin
          tmr_period[live_n]    = period;
          tmr_countdown[live_n] = period;
          tmr_ident[live_n]     = next_id;
          due_reports.push_back('{KIND_CREATED, next_id, 1'b1});
          live_n++;
          next_id++;
        end
      end
      OP_REMOVE: begin
        // newest match wins
        for (int s = live_n - 1; s >= 0 && hit < 0; s--) begin
          if (tmr_ident[s] == rid) hit = s;
        end
        if (hit >= 0) begin
          for (int s = hit; s < live_n - 1; s++) begin
            tmr_period[s]    = tmr_period[s+1];
            tmr_countdown[s] = tmr_countdown[s+1];
            tmr_ident[s]     = tmr_ident[s+1];
          end
          live_n--;
        end
      end
      OP_TICK: begin
        for (int s = live_n - 1; s >= 0; s--) begin
          if (tmr_countdown[s] >= PERIOD_W'(TICK_STEP_DEF)) begin
            tmr_countdown[s] = tmr_countdown[s] - PERIOD_W'(TICK_STEP_DEF);
          end else begin
            tmr_countdown[s] = tmr_period[s];
            if (fired.size() < MAX_RESULTS) fired.push_back(tmr_ident[s]);
          end
        end
        foreach (fired[k]) begin
          due_reports.push_back('{KIND_FIRED, fired[k], k == fired.size() - 1});
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_n  = 0;
      next_id = '0;
      due_reports.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (due_reports.size() == 0) begin
          $error("unexpected result: kind %0d event_id %0d last %0d",
                 res_i.kind, res_i.event_id, res_i.last);
          mismatch_cnt++;
        end else begin
          want = due_reports.pop_front();
          if (res_i.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, res_i.kind);
            mismatch_cnt++;
          end
          if (res_i.event_id !== want.ident) begin
            $error("event_id: expected %0d, got %0d", want.ident, res_i.event_id);
            mismatch_cnt++;
          end
          if (res_i.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, res_i.last);
            mismatch_cnt++;
          end
        end
      end
      if (evt_i.valid && evt_i.ready) begin
        apply_timer_op(evt_i.operation, evt_i.period_ms, evt_i.remove_id);
      end
    end
    reports_due = due_reports.size();
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the periodic event timer table. A short directed run covers
// the edge periods, a full table, an unknown operation and removes of absent,
// oldest and middle entries. A random run with bursty traffic, a long output
// stall and a full drain completes the test. Checking is done in pett_checker.
// ----------------------------------------------------------------------------
module tb_top import pett_pkg::*; ();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4 * SLOTS_DEF + 16;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int RANDOM_ITEMS = 115;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  int unsigned     mismatch_cnt;
  int unsigned     reports_due;
  int unsigned     cycle_cnt    = 0;
  logic            hold_off_req = 1'b0;
  int              burst_left   = 0;
  logic [ID_W-1:0] id_next      = '0;

  logic [PERIOD_W-1:0] edge_periods [5] = '{
    {PERIOD_W{1'b0}}, {PERIOD_W{1'b1}}, PERIOD_W'(TICK_STEP_DEF),
    PERIOD_W'(TICK_STEP_DEF - 1), PERIOD_W'(TICK_STEP_DEF + 1)
  };

  pett_in_if  evt_if ();
  pett_out_if res_if ();

  periodic_event_timer_table_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  pett_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .evt_i          (evt_if),
    .res_i          (res_if),
    .mismatch_cnt_o (mismatch_cnt),
    .reports_due_o  (reports_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_op(input logic [OP_W-1:0]     op,
                         input logic [PERIOD_W-1:0] period,
                         input logic [ID_W-1:0]     rid);
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) != 0) begin
        evt_if.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : int'($urandom_range(1, 10));
    end
    burst_left--;
    evt_if.valid     <= 1'b1;
    evt_if.operation <= op;
    evt_if.period_ms <= period;
    evt_if.remove_id <= rid;
    do @(posedge clk_i); while (!evt_if.ready);
  endtask

  task automatic drain();
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (reports_due != 0);
  endtask

  task automatic send_random_op();
    int unsigned         pick;
    logic [PERIOD_W-1:0] period;
    logic [ID_W-1:0]     rid;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 5))
      0:       period = PERIOD_W'($urandom);
      1:       period = PERIOD_W'($urandom_range(0, TICK_STEP_DEF));
      default: period = PERIOD_W'($urandom_range(0, 6 * TICK_STEP_DEF));
    endcase
    // mostly recent ids, which are likely still live
    if ($urandom_range(0, 4) == 0) rid = ID_W'($urandom);
    else rid = id_next - ID_W'($urandom_range(1, 20));
    if (pick < 35) begin
      send_op(OP_CREATE, period, rid);
      id_next++;
    end else if (pick < 65) begin
      send_op(OP_REMOVE, period, rid);
    end else if (pick < 95) begin
      send_op(OP_TICK, period, rid);
    end else begin
      send_op(OP_UNUSED, period, rid);
    end
  endtask

  // result side
  initial begin
    int run_len;
    int stall_len;
    run_len      = 0;
    stall_len    = 0;
    res_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        res_if.ready <= 1'b1;
      end else begin
        if (run_len == 0 && stall_len == 0) begin
          run_len   = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 40))
                                                  : int'($urandom_range(1, 6));
          stall_len = $urandom_range(1, 5);
        end
        if (run_len > 0) begin
          res_if.ready <= 1'b1;
          run_len--;
        end else begin
          res_if.ready <= 1'b0;
          stall_len--;
        end
      end
    end
  end

  // operation side
  initial begin
    evt_if.valid     = 1'b0;
    evt_if.operation = OP_TICK;
    evt_if.period_ms = '0;
    evt_if.remove_id = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge periods: zero, all ones, around the tick step
    foreach (edge_periods[k]) begin
      send_op(OP_CREATE, edge_periods[k], '0);
      id_next++;
    end
    send_op(OP_TICK, '0, '0);
    send_op(OP_TICK, {PERIOD_W{1'b1}}, {ID_W{1'b1}});
    send_op(OP_UNUSED, {PERIOD_W{1'b1}}, {ID_W{1'b1}});
    // absent id, then the all-ones period entry
    send_op(OP_REMOVE, '0, {ID_W{1'b1}});
    send_op(OP_REMOVE, '0, ID_W'(1));
    while (id_next < ID_W'(SLOTS_DEF + 1)) begin
      send_op(OP_CREATE, PERIOD_W'($urandom_range(0, 3 * TICK_STEP_DEF)), '0);
      id_next++;
    end
    // table full
    send_op(OP_CREATE, PERIOD_W'($urandom), '0);
    // middle entry, then the oldest
    send_op(OP_REMOVE, '0, ID_W'(2));
    send_op(OP_REMOVE, '0, ID_W'(0));
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 50) begin
        // long output stall while the sender keeps pushing
        hold_off_req = 1'b1;
        for (int k = 0; k < 10; k++) begin
          if (k % 2 == 0) begin
            send_op(OP_CREATE, '0, '0);
            id_next++;
          end else begin
            send_op(OP_TICK, '0, '0);
          end
        end
      end
      if (n == 100) drain();
      send_random_op();
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
